// ===== rtl/klis_pkg.sv =====
// Shared constants, types and codes for the key list block.
package klis_pkg;

  localparam int CAPACITY  = 128;
  localparam int KEY_W     = 160;
  localparam int POS_W     = 7;
  localparam int GRP_W     = 8;
  localparam int LOC_W     = $clog2(GRP_W);
  localparam int NGRP      = (CAPACITY + GRP_W - 1) / GRP_W;
  localparam int GRP_IDX_W = (NGRP > 1) ? $clog2(NGRP) : 1;

  typedef logic [KEY_W-1:0] key_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic ins;
    logic rem;
    logic cmp;
  } cell_ctl_t;

endpackage

// ===== rtl/klis_cell.sv =====
// One list slot: stored key, occupancy bit and registered compare result.
module klis_cell
  import klis_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  key_t      cmp_key,
  input  key_t      prev_key,
  input  logic      prev_occ,
  input  logic      next_occ,
  output key_t      key_r,
  output logic      occ_r,
  output logic      match_r
);

  logic occ_nxt;

  // Insert shifts towards the tail; remove pulls the occupancy edge back by one.
  always_comb begin
    if (ctl.ins) begin
      occ_nxt = prev_occ;
    end else if (ctl.rem) begin
      occ_nxt = next_occ;
    end else begin
      occ_nxt = occ_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      key_r <= prev_key;
    end
    if (ctl.cmp) begin
      match_r <= occ_r && (key_r == cmp_key);
    end
  end

endmodule

// ===== rtl/klis_match_enc.sv =====
// Two-level first-match encoder over the cell compare results.
module klis_match_enc
  import klis_pkg::*;
(
  input  logic                clk,
  input  logic                load,
  input  logic [CAPACITY-1:0] match,
  output logic                found,
  output logic [POS_W-1:0]    position
);

  logic [NGRP*GRP_W-1:0] match_pad;
  logic [NGRP-1:0]       grp_any_nxt;
  logic [LOC_W-1:0]      grp_idx_nxt [NGRP];
  logic [NGRP-1:0]       grp_any_r;
  logic [LOC_W-1:0]      grp_idx_r [NGRP];
  logic [GRP_IDX_W-1:0]  gsel;
  logic [LOC_W-1:0]      lsel;
  logic [POS_W+GRP_IDX_W+LOC_W-1:0] pos_ext;

  assign match_pad = (NGRP*GRP_W)'(match);

  // first stage: lowest set bit inside each group of eight
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_nxt[g] = |match_pad[g*GRP_W +: GRP_W];
      grp_idx_nxt[g] = '0;
      for (int j = GRP_W - 1; j >= 0; j--) begin
        if (match_pad[g*GRP_W + j]) begin
          grp_idx_nxt[g] = LOC_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_any_r <= grp_any_nxt;
      for (int g = 0; g < NGRP; g++) begin
        grp_idx_r[g] <= grp_idx_nxt[g];
      end
    end
  end

  // second stage: lowest group with a hit
  always_comb begin
    found = 1'b0;
    gsel  = '0;
    lsel  = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        found = 1'b1;
        gsel  = GRP_IDX_W'(g);
        lsel  = grp_idx_r[g];
      end
    end
  end

  assign pos_ext  = {{POS_W{1'b0}}, gsel, lsel};
  assign position = pos_ext[POS_W-1:0];

endmodule

// ===== rtl/key_list_insert_search_remove.sv =====
// Key list top level: row of key cells, first-match encoder and result register.
//
// Ordered list of up to CAPACITY 160-bit keys held in a row of cells. Insert puts
// the key at the head (status full when no room), remove drops the tail entry
// (status empty when nothing stored), search returns the head index of the first
// equal key (status empty or not found otherwise). One transaction is in flight at
// a time. Insert, remove and the unused code write the output register directly; a
// search first has the cells compare in parallel, then a two-level registered
// encoder picks the first hit. The result sits in an output register, and the next
// transaction is taken as soon as that register is empty or being read.
module key_list_insert_search_remove
  import klis_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [63:0] in_name_high,
  input  logic [63:0] in_name_middle,
  input  logic [31:0] in_name_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [6:0]  out_position
);

  typedef enum logic [1:0] {S_IDLE, S_GRP, S_FIN} state_t;

  state_t             state_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [POS_W-1:0]   out_position_r;

  key_t               in_key;
  op_t                op;
  logic               accept;
  logic               full;
  logic               empty;
  cell_ctl_t          ctl;
  status_t            res_status;
  logic               go_search;

  key_t               key_q [CAPACITY];
  logic [CAPACITY-1:0] occ_q;
  logic [CAPACITY-1:0] match_q;

  logic               enc_found;
  logic [POS_W-1:0]   enc_pos;

  assign in_key = {in_name_high, in_name_middle, in_name_low};
  assign op     = op_t'(in_operation);
  assign full   = occ_q[CAPACITY-1];
  assign empty  = !occ_q[0];

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    ctl        = '0;
    res_status = ST_OK;
    go_search  = 1'b0;
    unique case (op)
      OP_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          ctl.ins = accept;
        end
      end
      OP_SEARCH: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          ctl.cmp   = accept;
          go_search = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          ctl.rem = accept;
        end
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    key_t prev_key;
    logic prev_occ;
    logic next_occ;

    if (i == 0) begin : g_head
      assign prev_key = in_key;
      assign prev_occ = 1'b1;
    end else begin : g_mid
      assign prev_key = key_q[i-1];
      assign prev_occ = occ_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_occ = 1'b0;
    end else begin : g_body
      assign next_occ = occ_q[i+1];
    end

    klis_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .cmp_key  (in_key),
      .prev_key (prev_key),
      .prev_occ (prev_occ),
      .next_occ (next_occ),
      .key_r    (key_q[i]),
      .occ_r    (occ_q[i]),
      .match_r  (match_q[i])
    );
  end

  klis_match_enc u_enc (
    .clk      (clk),
    .load     (state_r == S_GRP),
    .match    (match_q),
    .found    (enc_found),
    .position (enc_pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a transaction that does not start a search reloads the register in the same cycle it is read
      if (out_valid_r && out_ready && !(accept && !go_search)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (go_search) begin
              state_r <= S_GRP;
            end else begin
              out_valid_r    <= 1'b1;
              out_status_r   <= res_status;
              out_position_r <= '0;
            end
          end
        end
        S_GRP: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          out_valid_r    <= 1'b1;
          out_status_r   <= enc_found ? ST_OK : ST_NOT_FOUND;
          out_position_r <= enc_found ? enc_pos : '0;
          state_r        <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;

endmodule
